// ===== design/gtwp_pkg.sv =====
// Package for the two-world projection pipeline: item type, work-format constants
// and the CORDIC arctangent table.
// Used by gilbert_two_world_projection; depends on nothing.
package gtwp_pkg;

   localparam int FRAC_BITS_DEF    = 14;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int WORK_BITS        = 30;
   // stages per middle segment (longest unit: 32 root steps plus one setup step)
   localparam int SEG_LEN          = 33;
   localparam int DIV_STEPS        = WORK_BITS;

   localparam logic signed [33:0] ONE_W     = 34'sd1073741824;
   localparam logic signed [33:0] PI_HALF_W = 34'sd1686629713;
   localparam logic signed [33:0] PI_W      = 34'sd3373259426;

   // one point as it moves down the pipeline
   typedef struct packed {
      logic signed [33:0] lx;      // latitude CORDIC vector and angle
      logic signed [33:0] ly;
      logic signed [33:0] lz;
      logic signed [33:0] wx;      // longitude CORDIC vector and angle
      logic signed [33:0] wy;
      logic signed [33:0] wz;
      logic               s_neg;
      logic               sn_neg;
      logic [31:0]        l_div;   // tangent divider
      logic [32:0]        l_rem;
      logic [29:0]        l_q;
      logic               l_one;
      logic [31:0]        w_div;   // sine divider
      logic [32:0]        w_rem;
      logic [29:0]        w_q;
      logic               w_one;
      logic               w_zero;
      logic [31:0]        mwy;
      logic [63:0]        sqx;
      logic [63:0]        l_val;   // root of 1 - s^2
      logic [63:0]        l_res;
      logic [63:0]        w_val;   // root of vector length squared
      logic [63:0]        w_res;
      logic [30:0]        smag;
      logic [61:0]        prod;
      logic [15:0]        px;
      logic [15:0]        py;
   } item_type;

   // atan(2^-i) in Q2.30, rounded to nearest
   function automatic logic signed [33:0] atan_w(input int idx);
      logic signed [33:0] r;
      case (idx)
         0: r = 34'sd843314857;
         1: r = 34'sd497837829;
         2: r = 34'sd263043837;
         3: r = 34'sd133525159;
         4: r = 34'sd67021687;
         5: r = 34'sd33543516;
         6: r = 34'sd16775851;
         7: r = 34'sd8388437;
         8: r = 34'sd4194283;
         9: r = 34'sd2097149;
         // small angles: 2^(30-i), rounded (the last entry rounds up to one)
         default: r = 34'((((64'(1) << (WORK_BITS + 1)) >> idx) + 64'(1)) >> 1);
      endcase
      return r;
   endfunction

endpackage

// ===== design/gilbert_two_world_projection.sv =====
// Gilbert two-world projection: one point in, one projected point out, fully pipelined.
// Depends on gtwp_pkg (item type, constants, arctangent table).
//
//  channel  | dir | tdata fields (low bit up)                    | tuser/tlast
//  req_     | in  | latitude[14:0], longitude[30:15], pad [31]   | none
//  rsp_     | out | plane_x[15:0], plane_y[31:16]                | none
//
// One item enters per cycle while the output register is empty or taken. The stages are:
// angle setup, the CORDIC stages, divider setup, two 33-stage segments (each a root unit
// beside a divider chain) and two output stages.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits only; payload registers carry no reset.
module gilbert_two_world_projection #(
   parameter int FRAC_BITS    = gtwp_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = gtwp_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // latitude[14:0], longitude[30:15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // plane_x[15:0], plane_y[31:16]
);

   localparam int K_PREP = CORDIC_STEPS + 1;
   localparam int K_A0   = K_PREP + 1;
   localparam int K_B0   = K_A0 + gtwp_pkg::SEG_LEN;
   localparam int K_FIN  = K_B0 + gtwp_pkg::SEG_LEN;
   localparam int NS     = K_FIN + 2;
   localparam int SHX    = 2 * gtwp_pkg::WORK_BITS - FRAC_BITS;
   localparam int SHY    = gtwp_pkg::WORK_BITS - FRAC_BITS;

   gtwp_pkg::item_type pipe_ff [NS];
   gtwp_pkg::item_type pipe_in [NS];
   logic [NS-1:0]      vld_ff;
   logic [NS-1:0]      vld_in;
   logic               adv;

   // one restoring divide step
   function automatic void div_step(input logic [31:0] dv, inout logic [32:0] rem,
                                    inout logic [29:0] q);
      logic [32:0] r2;
      r2 = {rem[31:0], 1'b0};
      if (r2 >= {1'b0, dv}) begin
         rem = r2 - {1'b0, dv};
         q   = {q[28:0], 1'b1};
      end else begin
         rem = r2;
         q   = {q[28:0], 1'b0};
      end
   endfunction

   // one floor square root step
   function automatic void sqrt_step(input logic [63:0] bitv, inout logic [63:0] val,
                                     inout logic [63:0] res);
      if (val >= res + bitv) begin
         val = val - (res + bitv);
         res = (res >> 1) + bitv;
      end else begin
         res = res >> 1;
      end
   endfunction

   // magnitude of a work-format value
   function automatic logic [31:0] mag32(input logic signed [33:0] v);
      logic signed [33:0] m;
      m = v[33] ? -v : v;
      return m[31:0];
   endfunction

   // clamp, sign and pack one output field
   function automatic logic [15:0] to_field(input logic [63:0] mag, input logic neg);
      logic [63:0] m;
      logic [63:0] v;
      m = (mag > (64'(1) << FRAC_BITS)) ? (64'(1) << FRAC_BITS) : mag;
      v = neg ? (64'(0) - m) : m;
      return v[15:0];
   endfunction

   // work done by stage k
   function automatic gtwp_pkg::item_type do_step(input int k, input gtwp_pkg::item_type a,
                                                  input logic [31:0] din);
      gtwp_pkg::item_type o;
      logic signed [33:0] hw;
      logic signed [33:0] at;
      logic [31:0]        my;
      logic [31:0]        mwx;
      logic [30:0]        sn;
      logic [63:0]        m;
      int                 i;
      int                 j;
      o = a;
      if (k == 0) begin
         // half angles, longitude folded into -pi/2..pi/2
         o.lz = {{3{din[14]}}, din[14:0], 16'b0};
         hw   = {{2{din[30]}}, din[30:15], 16'b0};
         if (hw > gtwp_pkg::PI_HALF_W) hw = gtwp_pkg::PI_W - hw;
         else if (hw < -gtwp_pkg::PI_HALF_W) hw = -gtwp_pkg::PI_W - hw;
         o.wz = hw;
         o.lx = gtwp_pkg::ONE_W;
         o.ly = '0;
         o.wx = gtwp_pkg::ONE_W;
         o.wy = '0;
      end else if (k <= CORDIC_STEPS) begin
         // rotation step on both vectors
         i  = k - 1;
         at = gtwp_pkg::atan_w(i);
         if (!a.lz[33]) begin
            o.lx = a.lx - (a.ly >>> i);
            o.ly = a.ly + (a.lx >>> i);
            o.lz = a.lz - at;
         end else begin
            o.lx = a.lx + (a.ly >>> i);
            o.ly = a.ly - (a.lx >>> i);
            o.lz = a.lz + at;
         end
         if (!a.wz[33]) begin
            o.wx = a.wx - (a.wy >>> i);
            o.wy = a.wy + (a.wx >>> i);
            o.wz = a.wz - at;
         end else begin
            o.wx = a.wx + (a.wy >>> i);
            o.wy = a.wy - (a.wx >>> i);
            o.wz = a.wz + at;
         end
      end else if (k == K_PREP) begin
         // divider setup for the tangent, first square for the vector length
         my      = mag32(a.ly);
         o.s_neg = a.ly[33];
         o.l_div = a.lx[31:0];
         o.l_one = (a.lx <= 0) || ($signed({2'b0, my}) >= a.lx);
         o.l_rem = {1'b0, my};
         o.l_q   = '0;
         mwx      = mag32(a.wx);
         o.sn_neg = a.wy[33];
         o.mwy    = mag32(a.wy);
         o.sqx    = 64'(mwx) * 64'(mwx);
      end else if (k < K_B0) begin
         j = k - K_A0;
         if (j < gtwp_pkg::DIV_STEPS) div_step(a.l_div, o.l_rem, o.l_q);
         if (j == 0) begin
            o.w_val = a.sqx + 64'(a.mwy) * 64'(a.mwy);
            o.w_res = '0;
         end else begin
            sqrt_step(64'(1) << (62 - 2 * (j - 1)), o.w_val, o.w_res);
         end
      end else if (k < K_FIN) begin
         j = k - K_B0;
         // latitude: clamp s, then root of 1 - s^2
         if (j == 0) begin
            o.smag = a.l_one ? 31'(gtwp_pkg::ONE_W) : {1'b0, a.l_q};
         end else if (j == 1) begin
            o.l_val = (64'(1) << (2 * gtwp_pkg::WORK_BITS)) - 64'(a.smag) * 64'(a.smag);
            o.l_res = '0;
         end else begin
            sqrt_step(64'(1) << (60 - 2 * (j - 2)), o.l_val, o.l_res);
         end
         // longitude: sine = |y| / length
         if (j == 0) begin
            o.w_div  = a.w_res[31:0];
            o.w_zero = (a.w_res == '0);
            o.w_one  = ({32'b0, a.mwy} >= a.w_res);
            o.w_rem  = {1'b0, a.mwy};
            o.w_q    = '0;
         end else if (j <= gtwp_pkg::DIV_STEPS) begin
            div_step(a.w_div, o.w_rem, o.w_q);
         end
      end else if (k == K_FIN) begin
         // sine times cosine term
         sn     = a.w_zero ? '0 : (a.w_one ? 31'(gtwp_pkg::ONE_W) : {1'b0, a.w_q});
         o.prod = 62'(sn) * 62'(a.l_res[30:0]);
      end else begin
         // round half away from zero and pack
         m    = (64'(a.prod) + ((64'(1) << SHX) >> 1)) >> SHX;
         o.px = to_field(m, !a.sn_neg);
         m    = (64'(a.smag) + ((64'(1) << SHY) >> 1)) >> SHY;
         o.py = to_field(m, a.s_neg);
      end
      return o;
   endfunction

   // whole pipeline moves when the output slot is free
   assign adv        = !vld_ff[NS-1] || rsp_tready;
   assign req_tready = adv;

   // stage logic
   for (genvar k = 0; k < NS; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign pipe_in[k] = do_step(k, pipe_ff[k], req_tdata);
         assign vld_in[k]  = req_tvalid;
      end else begin : g_rest
         assign pipe_in[k] = do_step(k, pipe_ff[k-1], req_tdata);
         assign vld_in[k]  = vld_ff[k-1];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {pipe_ff[NS-1].py, pipe_ff[NS-1].px};

`ifndef ASSERT_OFF
   // a stall freezes every valid bit
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during stall");

   // clamped tangent never exceeds one
   a_smag_one: assert property (@(posedge clock) disable iff (reset)
      vld_ff[K_B0] |-> (pipe_ff[K_B0].smag <= 31'(gtwp_pkg::ONE_W)))
      else $error("tangent magnitude above one");

   // divider remainder stays below divisor on the sine path
   a_wdiv_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[K_FIN-1] && !pipe_ff[K_FIN-1].w_one |->
         (pipe_ff[K_FIN-1].w_rem < {1'b0, pipe_ff[K_FIN-1].w_div}))
      else $error("sine divider remainder out of range");

   // output fields lie within -1..1
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (FRAC_BITS <= 14) |->
         (int'($signed(rsp_tdata[31:16])) <= (1 << FRAC_BITS)) &&
         (int'($signed(rsp_tdata[31:16])) >= -(1 << FRAC_BITS)) &&
         (int'($signed(rsp_tdata[15:0])) <= (1 << FRAC_BITS)) &&
         (int'($signed(rsp_tdata[15:0])) >= -(1 << FRAC_BITS)))
      else $error("projected point outside unit range");
`endif

endmodule

// ===== test/gilbert_two_world_projection_test.sv =====
// Self-checking testbench for gilbert_two_world_projection: random points go in over
// the req_ stream and each projected point is compared with a built-in fixed-point
// predictor. Depends on gtwp_pkg and the projection block.
module gilbert_two_world_projection_test;

   localparam int  FRAC = gtwp_pkg::FRAC_BITS_DEF;
   localparam int  STEPS = gtwp_pkg::CORDIC_STEPS_DEF;
   localparam int  WB = gtwp_pkg::WORK_BITS;
   localparam longint ONE_Q = 64'sd1 << WB;
   localparam longint HALF_PI_Q = 64'sd1686629713;
   localparam longint PI_Q = 64'sd3373259426;
   localparam int  IDLE_LIMIT = 3000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // latitude[14:0], longitude[30:15]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;       // plane_x[15:0], plane_y[31:16]

   logic [31:0] points_todo[$];
   logic [31:0] projected_due[$];
   longint      atan_q[32];
   int          send_gap, recv_stall, errors, idle_cycles;
   bit          send_quiet, recv_quiet;

   gilbert_two_world_projection DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   // atan(2^-i) in Q2.30 from the power series in Q60
   task automatic fill_atan();
      longint sum;
      int e;
      atan_q[0] = 64'sd843314857;
      for (int i = 1; i < 32; i++) begin
         sum = 0;
         for (int k = 0; ; k++) begin
            e = 60 - i * (2 * k + 1);
            if (e < 0) break;
            if (k & 1) sum -= longint'((64'd1 << e) / (2 * k + 1));
            else sum += longint'((64'd1 << e) / (2 * k + 1));
         end
         atan_q[i] = (sum + (64'sd1 << 29)) >>> 30;
      end
   endtask

   function automatic void rotate(input longint ang, output longint vx, output longint vy);
      longint dx, dy;
      vx = ONE_Q;
      vy = 0;
      for (int i = 0; i < STEPS && i < 32; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (ang >= 0) begin
            vx -= dx; vy += dy; ang -= atan_q[i];
         end else begin
            vx += dx; vy -= dy; ang += atan_q[i];
         end
      end
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // round half away, saturate to one, sign, trim to 16 bits
   function automatic logic [15:0] to_q14(input logic [63:0] m, input int sh, input bit neg);
      logic [63:0] v;
      v = (m + (64'd1 << (sh - 1))) >> sh;
      if (v > (64'd1 << FRAC)) v = 64'd1 << FRAC;
      if (neg) v = -v;
      return v[15:0];
   endfunction

   // returns {plane_y, plane_x} for one packed point
   function automatic logic [31:0] project_point(input logic [31:0] pt);
      longint lat, lon, hw, cx, cy, wx, wy;
      logic [63:0] smag, c, mwx, mwy, r, sn;
      lat = longint'($signed(pt[14:0]));
      lon = longint'($signed(pt[30:15]));
      rotate(lat * 65536, cx, cy);
      smag = cy < 0 ? -cy : cy;
      if (cx <= 0) smag = ONE_Q;
      else smag = (smag << WB) / cx;
      if (smag > ONE_Q) smag = ONE_Q;
      c = floor_root((64'd1 << 60) - smag * smag);
      // fold the half longitude back into the convergence range
      hw = lon * 65536;
      if (hw > HALF_PI_Q) hw = PI_Q - hw;
      else if (hw < -HALF_PI_Q) hw = -PI_Q - hw;
      rotate(hw, wx, wy);
      mwx = wx < 0 ? -wx : wx;
      mwy = wy < 0 ? -wy : wy;
      r = floor_root(mwx * mwx + mwy * mwy);
      sn = r != 0 ? (mwy << WB) / r : 0;
      if (sn > ONE_Q) sn = ONE_Q;
      return {to_q14(smag, WB - FRAC, cy < 0), to_q14(sn * c, 2 * WB - FRAC, !(wy < 0))};
   endfunction

   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 99) < 4) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [31:0] pack_point(input int lat, input int lon);
      return {1'b0, 16'(lon), 15'(lat)};
   endfunction

   // driver: feeds pending points, books an expectation per accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) projected_due.push_back(project_point(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 || points_todo.size() == 0) begin
               req_tvalid <= 0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               req_tvalid <= 1;
               req_tdata <= points_todo.pop_front();
               send_gap <= draw_wait(send_quiet);
            end
         end
      end
   end

   // monitor: random backpressure, compares each result with the oldest expectation
   always @(posedge clock) begin
      int nstall;
      logic [31:0] want;
      if (reset) begin
         rsp_tready <= 0;
         recv_stall <= 0;
      end else begin
         nstall = recv_stall;
         if (rsp_tvalid && rsp_tready) begin
            nstall = draw_wait(recv_quiet);
            if (projected_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, actual %h", $realtime, rsp_tdata);
            end else begin
               want = projected_due.pop_front();
               if (want[15:0] !== rsp_tdata[15:0]) begin
                  errors++;
                  $display("%0t: plane_x expected %h actual %h", $realtime, want[15:0],
                           rsp_tdata[15:0]);
               end
               if (want[31:16] !== rsp_tdata[31:16]) begin
                  errors++;
                  $display("%0t: plane_y expected %h actual %h", $realtime, want[31:16],
                           rsp_tdata[31:16]);
               end
            end
         end
         if (nstall > 0) begin
            rsp_tready <= 0;
            recv_stall <= nstall - 1;
         end else begin
            rsp_tready <= 1;
            recv_stall <= 0;
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int lat_edges[] = '{0, 1, -1, 12868, -12868, 16383, -16384};
      int lon_edges[] = '{0, 25735, 25736, -25736, 32767, -32768, 12868, -12869};
      fill_atan();
      errors = 0;
      // field extremes and the longitude fold boundaries
      foreach (lat_edges[i]) points_todo.push_back(pack_point(lat_edges[i], lon_edges[i]));
      foreach (lon_edges[i]) points_todo.push_back(pack_point(lat_edges[i % 7], lon_edges[i]));
      points_todo.push_back(pack_point(16383, -32768));
      points_todo.push_back(pack_point(-16384, 32767));
      // mostly nominal-range points, some using the whole field
      repeat (1850) begin
         if ($urandom_range(0, 3) == 0)
            points_todo.push_back({1'b0, 31'($urandom)});
         else
            points_todo.push_back(pack_point($urandom_range(0, 25736) - 12868,
                                             $urandom_range(0, 51472) - 25736));
      end
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (points_todo.size() != 0 || req_tvalid || projected_due.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
design/gtwp_pkg.sv
design/gilbert_two_world_projection.sv
test/gilbert_two_world_projection_test.sv
